// ===== hdl/msnp_pkg.sv =====
// Shared types, constants and codes for the multi-stack node pool block.
// No dependencies; every other file in hdl/ imports this package.
package msnp_pkg;

  localparam int NUM_STACKS  = 10;
  localparam int POOL_DEPTH  = 64;
  localparam int MAX_RESULTS = 64;

  localparam int VAL_W     = 32;
  localparam int POS_W     = 7;
  localparam int PTR_W     = $clog2(POOL_DEPTH + 1);   // node index plus null
  localparam int IDX_W     = $clog2(POOL_DEPTH);
  localparam int SEL_IDX_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

  localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_DEPTH);

  // op codes
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_LIST = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]              op;
    logic [3:0]              stack_sel;
    logic signed [VAL_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
    logic                    last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_PUSH_WR,
    S_POP_WR,
    S_LIST
  } state_t;

  typedef enum logic [1:0] {
    RD_HEAD,
    RD_FREE,
    RD_LINK
  } rd_src_t;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_OK,
    EM_EMPTY,
    EM_FULL,
    EM_POP,
    EM_LIST
  } emit_t;

  // controller -> datapath
  typedef struct packed {
    logic    load_item;
    logic    rd_en;
    rd_src_t rd_src;
    logic    push_fresh;
    logic    push_recycle;
    logic    pop_commit;
    logic    list_step;
    emit_t   emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic       sel_valid;
    logic       head_null;
    logic       free_null;
    logic       fresh_full;
    logic       out_free;
    logic       list_last;
  } stat_t;

endpackage

// ===== hdl/msnp_ctrl.sv =====
// Sequencer for the multi-stack node pool: decode, memory read/write steps, list walk.
// Depends on msnp_pkg; drives msnp_dp through cmd_t, reads stat_t.
module msnp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  msnp_pkg::stat_t stat,
  output msnp_pkg::cmd_t  cmd
);
  import msnp_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    cmd.load_item    = 1'b0;
    cmd.rd_en        = 1'b0;
    cmd.rd_src       = RD_HEAD;
    cmd.push_fresh   = 1'b0;
    cmd.push_recycle = 1'b0;
    cmd.pop_commit   = 1'b0;
    cmd.list_step    = 1'b0;
    cmd.emit         = EM_NONE;
    in_stall         = 1'b1;

    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DEC;
        end
      end

      S_DEC: begin
        case (stat.op)
          OP_PUSH: begin
            if (!stat.sel_valid || (stat.free_null && stat.fresh_full)) begin
              if (stat.out_free) begin
                cmd.emit  = EM_FULL;
                state_nxt = S_IDLE;
              end
            end else if (!stat.free_null) begin
              // recycled node: fetch its link first
              cmd.rd_en  = 1'b1;
              cmd.rd_src = RD_FREE;
              state_nxt  = S_PUSH_WR;
            end else if (stat.out_free) begin
              cmd.push_fresh = 1'b1;
              cmd.emit       = EM_OK;
              state_nxt      = S_IDLE;
            end
          end
          OP_POP, OP_LIST: begin
            if (!stat.sel_valid || stat.head_null) begin
              if (stat.out_free) begin
                cmd.emit  = EM_EMPTY;
                state_nxt = S_IDLE;
              end
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_src = RD_HEAD;
              state_nxt  = (stat.op == OP_POP) ? S_POP_WR : S_LIST;
            end
          end
          default: begin
            state_nxt = S_IDLE;   // unused op: no result
          end
        endcase
      end

      S_PUSH_WR: begin
        if (stat.out_free) begin
          cmd.push_recycle = 1'b1;
          cmd.emit         = EM_OK;
          state_nxt        = S_IDLE;
        end
      end

      S_POP_WR: begin
        if (stat.out_free) begin
          cmd.pop_commit = 1'b1;
          cmd.emit       = EM_POP;
          state_nxt      = S_IDLE;
        end
      end

      S_LIST: begin
        if (stat.out_free) begin
          cmd.list_step = 1'b1;
          cmd.emit      = EM_LIST;
          if (stat.list_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_src = RD_LINK;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/msnp_dp.sv =====
// Datapath: stack heads, free list, node memories, result register.
// Depends on msnp_pkg; steered by msnp_ctrl via cmd_t.
module msnp_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  msnp_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output msnp_pkg::out_item_t out_item,
  input  msnp_pkg::cmd_t      cmd,
  output msnp_pkg::stat_t     stat
);
  import msnp_pkg::*;

  logic [PTR_W-1:0] head_r [NUM_STACKS];
  logic [PTR_W-1:0] free_head_r;
  logic [PTR_W-1:0] fresh_r;
  in_item_t         item_r;
  logic [POS_W-1:0] cnt_r;

  logic signed [VAL_W-1:0] val_mem_r  [POOL_DEPTH];
  logic [PTR_W-1:0]        next_mem_r [POOL_DEPTH];
  logic signed [VAL_W-1:0] rd_val_r;
  logic [PTR_W-1:0]        rd_next_r;

  logic      out_valid_r;
  out_item_t out_r, out_nxt;

  logic                 sel_valid;
  logic [SEL_IDX_W-1:0] sel_idx;
  logic [PTR_W-1:0]     head_cur;
  logic [IDX_W-1:0]     rd_idx;
  logic [IDX_W-1:0]     wr_idx;
  logic [PTR_W-1:0]     next_wdata;
  logic                 val_we;
  logic                 next_we;
  logic                 out_free;
  logic                 list_last;

  assign sel_valid = (32'(item_r.stack_sel) < NUM_STACKS);
  assign sel_idx   = item_r.stack_sel[SEL_IDX_W-1:0];
  assign head_cur  = sel_valid ? head_r[sel_idx] : NIL;
  assign out_free  = !out_valid_r || !out_stall;
  assign list_last = (rd_next_r == NIL) || (cnt_r == POS_W'(MAX_RESULTS - 1));

  assign stat.op         = item_r.op;
  assign stat.sel_valid  = sel_valid;
  assign stat.head_null  = (head_cur == NIL);
  assign stat.free_null  = (free_head_r == NIL);
  assign stat.fresh_full = (fresh_r == NIL);
  assign stat.out_free   = out_free;
  assign stat.list_last  = list_last;

  always_comb begin
    case (cmd.rd_src)
      RD_HEAD: rd_idx = head_cur[IDX_W-1:0];
      RD_FREE: rd_idx = free_head_r[IDX_W-1:0];
      RD_LINK: rd_idx = rd_next_r[IDX_W-1:0];
      default: rd_idx = head_cur[IDX_W-1:0];
    endcase
  end

  always_comb begin
    val_we     = cmd.push_fresh || cmd.push_recycle;
    next_we    = val_we || cmd.pop_commit;
    wr_idx     = head_cur[IDX_W-1:0];
    next_wdata = head_cur;
    if (cmd.push_fresh) begin
      wr_idx = fresh_r[IDX_W-1:0];
    end else if (cmd.push_recycle) begin
      wr_idx = free_head_r[IDX_W-1:0];
    end else if (cmd.pop_commit) begin
      next_wdata = free_head_r;   // popped node goes on the free list
    end
  end

  // node memories, registered read
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_val_r  <= val_mem_r[rd_idx];
      rd_next_r <= next_mem_r[rd_idx];
    end
    if (val_we) begin
      val_mem_r[wr_idx] <= item_r.push_value;
    end
    if (next_we) begin
      next_mem_r[wr_idx] <= next_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        head_r[i] <= NIL;
      end
      free_head_r <= NIL;
      fresh_r     <= '0;
    end else begin
      if (cmd.push_fresh) begin
        head_r[sel_idx] <= fresh_r;
        fresh_r         <= fresh_r + PTR_W'(1);
      end else if (cmd.push_recycle) begin
        head_r[sel_idx] <= free_head_r;
        free_head_r     <= rd_next_r;
      end else if (cmd.pop_commit) begin
        head_r[sel_idx] <= rd_next_r;
        free_head_r     <= head_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_item;
      cnt_r  <= '0;
    end else if (cmd.list_step) begin
      cnt_r <= cnt_r + POS_W'(1);
    end
  end

  always_comb begin
    out_nxt.status   = ST_OK;
    out_nxt.value    = '0;
    out_nxt.position = '0;
    out_nxt.last     = 1'b1;
    case (cmd.emit)
      EM_EMPTY: out_nxt.status = ST_EMPTY;
      EM_FULL:  out_nxt.status = ST_FULL;
      EM_POP:   out_nxt.value  = rd_val_r;
      EM_LIST: begin
        out_nxt.value    = rd_val_r;
        out_nxt.position = cnt_r + POS_W'(1);
        out_nxt.last     = list_last;
      end
      default: out_nxt.status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit != EM_NONE) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != EM_NONE) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== hdl/multi_stack_shared_node_pool_core.sv =====
// Steps: fresh push, empty and full cases decode, then load the result; recycled push
//   and pop do one node-memory read, then the write; list reads one node per result.
// Throughput: one item at a time; the next is taken once the last item's final result
//   is loaded. The list walk runs at one node per cycle while the output is not stalled.
// Reset (sync, active low): all stacks empty, free list null, no nodes handed out yet.
//   Node memories are not cleared; no clearing pass.
module multi_stack_shared_node_pool_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  msnp_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output msnp_pkg::out_item_t out_item
);
  import msnp_pkg::*;

  // Controller owns sequencing: it takes an item only in idle, decodes op and
  // stack state, and steps the datapath one memory access at a time.
  cmd_t  cmd;
  stat_t stat;

  msnp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath holds the per-stack head pointers, the free list head, the index
  // of the next never-used node, the value/link memories and the result register.
  // The result register lets a new item in while a result still waits.
  msnp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== hdl/msnp_chk.sv =====
// Port-level checks for multi_stack_shared_node_pool_core, bound to the top level.
// Depends on msnp_pkg.
module msnp_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input msnp_pkg::out_item_t out_item
);
  import msnp_pkg::*;

  // one item at a time: an accepted item closes the input for the next cycle
  a_seq_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted on back-to-back cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status == ST_OK || out_item.status == ST_EMPTY ||
                   out_item.status == ST_FULL))
    else $error("undefined status code");

  a_pos_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.position != '0) |-> (out_item.status == ST_OK))
    else $error("listed element with error status");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != ST_OK) |->
      (out_item.last && out_item.value == '0 && out_item.position == '0))
    else $error("error result not a lone zero result");

endmodule

bind multi_stack_shared_node_pool_core msnp_chk u_chk (.*);

// ===== test/multi_stack_shared_node_pool_core_tb.sv =====
// Self-checking bench for multi_stack_shared_node_pool_core: push, pop and list traffic on the
// linked stacks, with results predicted in-bench and compared in order as they arrive.
// Depends on msnp_pkg (hdl/msnp_pkg.sv) and the core RTL.
`timescale 1ns / 1ps

module multi_stack_shared_node_pool_core_tb;
  import msnp_pkg::*;

  // op code 3 is unassigned: the block swallows it without a result
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_PCT  = 18;
  localparam int HOLD_LEN  = 150;  // receiver hold-off, in cycles
  localparam int TAIL_WAIT = 80;   // > longest list walk plus pipeline

  typedef struct {
    in_item_t item;
    bit       drain_first;  // sender waits for every outstanding result first
  } script_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  multi_stack_shared_node_pool_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the stacks and the shared pool.
  // Null link is POOL_DEPTH, same as the block.
  // ---------------------------------------------------------------------------
  logic [PTR_W-1:0] shadow_head [NUM_STACKS];
  logic [VAL_W-1:0] shadow_val  [POOL_DEPTH];
  logic [PTR_W-1:0] shadow_next [POOL_DEPTH];
  logic [PTR_W-1:0] shadow_free;
  logic [PTR_W-1:0] shadow_fresh;

  out_item_t pending_results[$];  // results the block still owes, oldest first
  script_t   op_script[$];        // items not yet offered
  script_t   next_entry;

  int taken_count = 0;  // items accepted so far
  int errors      = 0;
  int n_checked   = 0;
  int n_empty     = 0;
  int n_full      = 0;
  int deepest     = 0;
  int hold_left   = 0;
  bit held_off    = 1'b0;
  int hold_at     = -1;  // accepted-count that triggers the hold-off
  int calm_lo     = 0;   // window (in accepted items) with no idling at all
  int calm_hi     = 0;

  wire calm = (taken_count >= calm_lo) && (taken_count < calm_hi);

  function automatic void owe(input logic [1:0] st, input logic [VAL_W-1:0] v,
                              input int pos, input bit lst);
    out_item_t r;
    r.status   = st;
    r.value    = v;
    r.position = POS_W'(pos);
    r.last     = lst;
    pending_results.push_back(r);
  endfunction

  // Apply one accepted item to the shadow pool and queue what it should produce.
  task automatic apply_stack_op(input in_item_t it);
    logic [PTR_W-1:0] node;
    logic [PTR_W-1:0] h;
    bit               sel_ok;
    int               k;
    sel_ok = it.stack_sel < NUM_STACKS;
    case (it.op)
      OP_PUSH: begin
        node = NIL;
        if (sel_ok) begin
          if (shadow_free < NIL) begin
            // recycled nodes are used before untouched ones
            node        = shadow_free;
            shadow_free = shadow_next[node[IDX_W-1:0]];
          end else if (shadow_fresh < NIL) begin
            node         = shadow_fresh;
            shadow_fresh = shadow_fresh + 1'b1;
          end
        end
        if (node == NIL) begin
          owe(ST_FULL, '0, 0, 1'b1);  // out-of-range stack or pool exhausted
        end else begin
          shadow_val[node[IDX_W-1:0]]  = it.push_value;
          shadow_next[node[IDX_W-1:0]] = shadow_head[it.stack_sel];
          shadow_head[it.stack_sel]    = node;
          owe(ST_OK, '0, 0, 1'b1);
        end
      end
      OP_POP: begin
        h = sel_ok ? shadow_head[it.stack_sel] : NIL;
        if (h >= NIL) begin
          owe(ST_EMPTY, '0, 0, 1'b1);
        end else begin
          shadow_head[it.stack_sel]   = shadow_next[h[IDX_W-1:0]];
          shadow_next[h[IDX_W-1:0]]   = shadow_free;
          shadow_free                 = h;
          owe(ST_OK, shadow_val[h[IDX_W-1:0]], 0, 1'b1);
        end
      end
      OP_LIST: begin
        h = sel_ok ? shadow_head[it.stack_sel] : NIL;
        if (h >= NIL) begin
          owe(ST_EMPTY, '0, 0, 1'b1);
        end else begin
          // walk top to bottom; the walk is capped at MAX_RESULTS entries
          k = 0;
          while (h < NIL && k < MAX_RESULTS) begin
            owe(ST_OK, shadow_val[h[IDX_W-1:0]], k + 1,
                (shadow_next[h[IDX_W-1:0]] >= NIL) || (k + 1 == MAX_RESULTS));
            k++;
            h = shadow_next[h[IDX_W-1:0]];
          end
        end
      end
      default: ;  // unused op: no state change, no result
    endcase
  endtask

  task automatic report(input string field, input logic [VAL_W-1:0] got,
                        input logic [VAL_W-1:0] want);
    $display("%0t ns: %s mismatch, got %0h expected %0h", $time, field, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Sender: offers items from op_script, holds a stalled item steady, idles at
  // random outside the calm window. Prediction happens at the accepting edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item  <= '0;
      for (int s = 0; s < NUM_STACKS; s++) shadow_head[s] = NIL;
      shadow_free  = NIL;
      shadow_fresh = '0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_stack_op(in_item);
        taken_count <= taken_count + 1;
      end
      // only pick a new item when nothing is held on the channel
      if (!in_valid || !in_stall) begin
        if (op_script.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT) &&
            !(op_script[0].drain_first && pending_results.size() != 0)) begin
          next_entry = op_script.pop_front();
          in_valid <= 1'b1;
          in_item  <= next_entry.item;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: checks each accepted result against the oldest prediction and
  // drives out_stall (random, or one long hold-off after the deep list).
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report("unexpected result, status", VAL_W'(out_item.status), '0);
        end else begin
          automatic out_item_t want = pending_results.pop_front();
          if (out_item.status !== want.status)
            report("status", VAL_W'(out_item.status), VAL_W'(want.status));
          if (out_item.value !== want.value)
            report("value", out_item.value, want.value);
          if (out_item.position !== want.position)
            report("position", VAL_W'(out_item.position), VAL_W'(want.position));
          if (out_item.last !== want.last)
            report("last", VAL_W'(out_item.last), VAL_W'(want.last));
          n_checked++;
          if (want.status == ST_EMPTY) n_empty++;
          if (want.status == ST_FULL) n_full++;
          if (int'(want.position) > deepest) deepest = int'(want.position);
        end
      end
      // long hold-off: the sender keeps offering, so the block backs up
      if (!held_off && taken_count == hold_at) begin
        hold_left = HOLD_LEN;
        held_off  = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  function automatic void plan(input logic [1:0] op, input int sel,
                               input logic [VAL_W-1:0] v, input bit drain = 1'b0);
    script_t e;
    e.item.op         = op;
    e.item.stack_sel  = 4'(sel);
    e.item.push_value = v;
    e.drain_first     = drain;
    op_script.push_back(e);
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus plan and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int fill_stack;
    int fill_start;
    int r;
    int sel;

    // directed: empty stacks, value extremes, recycling, bad stack numbers,
    // unused op; every stack is empty again at the end of this part
    plan(OP_POP,    0, '0);
    plan(OP_LIST,   0, '0);
    plan(OP_PUSH,   0, 32'h7FFF_FFFF);
    plan(OP_PUSH,   0, 32'h8000_0000);
    plan(OP_PUSH,   9, 32'hFFFF_FFFF);
    plan(OP_PUSH,   0, 32'h0000_0000);
    plan(OP_LIST,   0, '0);
    plan(OP_POP,    0, '0);
    plan(OP_PUSH,  15, 32'h1234_5678);  // stack out of range: dropped as full
    plan(OP_POP,   10, '0);
    plan(OP_LIST,  15, '0);
    plan(OP_UNUSED, 0, 32'hFFFF_FFFF);
    plan(OP_POP,    0, '0);
    plan(OP_PUSH,   0, 32'h5555_5555);  // reuses a freed node
    plan(OP_LIST,   9, '0);
    plan(OP_POP,    9, '0);
    plan(OP_POP,    0, '0);
    plan(OP_POP,    0, '0);
    plan(OP_POP,    0, '0);
    plan(OP_UNUSED, 12, 32'hAAAA_AAAA);
    plan(OP_LIST,   0, '0);

    // fill the whole pool into one stack (recycled nodes first), overflow it,
    // then list all 64 entries; the receiver holds off right after that list
    fill_stack = $urandom_range(NUM_STACKS - 1);
    fill_start = op_script.size();
    calm_lo    = fill_start + 5;
    calm_hi    = fill_start + 45;
    for (int i = 0; i < POOL_DEPTH; i++) plan(OP_PUSH, fill_stack, pick_value(), i == 0);
    plan(OP_PUSH, fill_stack, pick_value());
    plan(OP_PUSH, (fill_stack + 1) % NUM_STACKS, pick_value());
    plan(OP_LIST, fill_stack, '0);
    hold_at = op_script.size();
    for (int i = 0; i < 30; i++) plan(OP_POP, fill_stack, '0);

    // random traffic, concentrated on a few stacks so they get deep
    for (int i = 0; i < 70; i++) begin
      r   = $urandom_range(99);
      sel = ($urandom_range(9) == 0) ? $urandom_range(NUM_STACKS - 1) : $urandom_range(3);
      if (r < 45)      plan(OP_PUSH, sel, pick_value(), i == 0);
      else if (r < 72) plan(OP_POP, sel, pick_value(), i == 0);
      else if (r < 86) plan(OP_LIST, sel, pick_value(), i == 0);
      else if (r < 95) plan(2'($urandom_range(2)), $urandom_range(15, NUM_STACKS), pick_value());
      else             plan(OP_UNUSED, $urandom_range(15), pick_value());
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (op_script.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("Ran %0d items through the stacks; %0d results checked, %0d empty, %0d full.",
             taken_count, n_checked, n_empty, n_full);
    $display("Deepest list position %0d, pool filled and recycled, %0d-cycle output hold-off.",
             deepest, HOLD_LEN);
    if (errors == 0) begin
      $display("multi_stack_shared_node_pool_core_tb: PASS");
    end else begin
      $display("multi_stack_shared_node_pool_core_tb: FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("multi_stack_shared_node_pool_core_tb: FAIL");
    $finish;
  end

endmodule

// ===== multi_stack_shared_node_pool_core.f =====
hdl/msnp_pkg.sv
hdl/msnp_ctrl.sv
hdl/msnp_dp.sv
hdl/multi_stack_shared_node_pool_core.sv
hdl/msnp_chk.sv
test/multi_stack_shared_node_pool_core_tb.sv
